/* rtl/pthm_pkg.sv */
// ----------------------------------------------------------------------------
// Homography map package
// Shared widths, register indexes, coefficient and sideband types.
// ----------------------------------------------------------------------------
package pthm_pkg;

    localparam int COEF_W        = 32;
    localparam int CFG_W         = 64;
    localparam int CFG_IDX_W     = 3;
    localparam int HEIGHT_W      = 32;
    localparam int OUT_W         = 48;
    localparam int OUT_FRAC_BITS = 16;
    localparam int OUT_INT_BITS  = OUT_W - OUT_FRAC_BITS;

    localparam logic [CFG_IDX_W-1:0] CFG_ROW0_A         = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW0_B_ROW1_A  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW1_B         = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW2_A         = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW2_C         = 3'd4;

    localparam logic [OUT_W-1:0] OUT_POS_MAX = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic [OUT_W-1:0] OUT_NEG_MAX = {1'b1, {(OUT_W-1){1'b0}}};

    typedef struct packed {
        logic signed [COEF_W-1:0] h00;
        logic signed [COEF_W-1:0] h01;
        logic signed [COEF_W-1:0] h02;
        logic signed [COEF_W-1:0] h10;
        logic signed [COEF_W-1:0] h11;
        logic signed [COEF_W-1:0] h12;
        logic signed [COEF_W-1:0] h20;
        logic signed [COEF_W-1:0] h21;
        logic signed [COEF_W-1:0] h22;
    } t_coefs;

    typedef struct packed {
        logic                zero;
        logic                neg_u;
        logic                neg_v;
        logic [HEIGHT_W-1:0] height;
    } t_side;

    typedef struct packed {
        logic [OUT_W-1:0]    scene_x;
        logic [OUT_W-1:0]    scene_y;
        logic [HEIGHT_W-1:0] height;
        logic                zero;
    } t_result;

endpackage

/* rtl/pthm_cfg_regs.sv */
// ----------------------------------------------------------------------------
// Homography coefficient registers
// Five write-only registers holding the nine signed matrix coefficients.
// ----------------------------------------------------------------------------
module pthm_cfg_regs
    import pthm_pkg::*;
#(
    parameter int COEF_FRAC_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    output t_coefs               o_coefs
);

    localparam logic [CFG_W-1:0]  ONE_64 = CFG_W'(1) << COEF_FRAC_BITS;
    localparam logic [COEF_W-1:0] ONE_32 = COEF_W'(1) << COEF_FRAC_BITS;

    logic [CFG_W-1:0]  r_row0_a;
    logic [CFG_W-1:0]  r_row0_b_row1_a;
    logic [CFG_W-1:0]  r_row1_b;
    logic [CFG_W-1:0]  r_row2_a;
    logic [COEF_W-1:0] r_row2_c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row0_a        <= ONE_64;
            r_row0_b_row1_a <= '0;
            r_row1_b        <= ONE_64;
            r_row2_a        <= '0;
            r_row2_c        <= ONE_32;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_ROW0_A:        r_row0_a        <= i_cfg_data;
                CFG_ROW0_B_ROW1_A: r_row0_b_row1_a <= i_cfg_data;
                CFG_ROW1_B:        r_row1_b        <= i_cfg_data;
                CFG_ROW2_A:        r_row2_a        <= i_cfg_data;
                CFG_ROW2_C:        r_row2_c        <= i_cfg_data[COEF_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_coefs.h00 = r_row0_a[COEF_W-1:0];
    assign o_coefs.h01 = r_row0_a[CFG_W-1:COEF_W];
    assign o_coefs.h02 = r_row0_b_row1_a[COEF_W-1:0];
    assign o_coefs.h10 = r_row0_b_row1_a[CFG_W-1:COEF_W];
    assign o_coefs.h11 = r_row1_b[COEF_W-1:0];
    assign o_coefs.h12 = r_row1_b[CFG_W-1:COEF_W];
    assign o_coefs.h20 = r_row2_a[COEF_W-1:0];
    assign o_coefs.h21 = r_row2_a[CFG_W-1:COEF_W];
    assign o_coefs.h22 = r_row2_c;

endmodule

/* rtl/pthm_dot.sv */
// ----------------------------------------------------------------------------
// Homography dot products
// Three stages: coefficient products, row sums, then magnitudes, quotient
// signs and the zero divisor flag.
// ----------------------------------------------------------------------------
module pthm_dot
    import pthm_pkg::*;
#(
    parameter int PIXEL_BITS = 13,
    localparam int PROD_W = COEF_W + PIXEL_BITS + 1,
    localparam int MAG_W  = PROD_W + 2
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  logic [PIXEL_BITS-1:0] i_pixel_x,
    input  logic [PIXEL_BITS-1:0] i_pixel_y,
    input  logic [HEIGHT_W-1:0]   i_height,
    input  t_coefs                i_coefs,
    output logic                  o_valid,
    output logic [MAG_W-1:0]      o_num_u,
    output logic [MAG_W-1:0]      o_num_v,
    output logic [MAG_W-1:0]      o_den,
    output t_side                 o_side
);

    logic signed [PIXEL_BITS:0] x_s;
    logic signed [PIXEL_BITS:0] y_s;

    logic                     r_vld1;
    logic                     r_vld2;
    logic                     r_vld3;
    logic signed [PROD_W-1:0] r_p00;
    logic signed [PROD_W-1:0] r_p01;
    logic signed [PROD_W-1:0] r_p10;
    logic signed [PROD_W-1:0] r_p11;
    logic signed [PROD_W-1:0] r_p20;
    logic signed [PROD_W-1:0] r_p21;
    logic [HEIGHT_W-1:0]      r_height1;
    logic [HEIGHT_W-1:0]      r_height2;
    logic signed [MAG_W-1:0]  r_u;
    logic signed [MAG_W-1:0]  r_v;
    logic signed [MAG_W-1:0]  r_w;
    logic [MAG_W-1:0]         r_num_u;
    logic [MAG_W-1:0]         r_num_v;
    logic [MAG_W-1:0]         r_den;
    t_side                    r_side;

    assign x_s = {1'b0, i_pixel_x};
    assign y_s = {1'b0, i_pixel_y};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
            r_vld3 <= 1'b0;
        end else if (i_en) begin
            r_vld1 <= i_valid;
            r_vld2 <= r_vld1;
            r_vld3 <= r_vld2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p00     <= i_coefs.h00 * x_s;
            r_p01     <= i_coefs.h01 * y_s;
            r_p10     <= i_coefs.h10 * x_s;
            r_p11     <= i_coefs.h11 * y_s;
            r_p20     <= i_coefs.h20 * x_s;
            r_p21     <= i_coefs.h21 * y_s;
            r_height1 <= i_height;

            r_u       <= r_p00 + r_p01 + i_coefs.h02;
            r_v       <= r_p10 + r_p11 + i_coefs.h12;
            r_w       <= r_p20 + r_p21 + i_coefs.h22;
            r_height2 <= r_height1;

            r_num_u       <= r_u[MAG_W-1] ? $unsigned(-r_u) : $unsigned(r_u);
            r_num_v       <= r_v[MAG_W-1] ? $unsigned(-r_v) : $unsigned(r_v);
            r_den         <= r_w[MAG_W-1] ? $unsigned(-r_w) : $unsigned(r_w);
            r_side.zero   <= (r_w == '0);
            r_side.neg_u  <= r_u[MAG_W-1] ^ r_w[MAG_W-1];
            r_side.neg_v  <= r_v[MAG_W-1] ^ r_w[MAG_W-1];
            r_side.height <= r_height2;
        end
    end

    assign o_valid = r_vld3;
    assign o_num_u = r_num_u;
    assign o_num_v = r_num_v;
    assign o_den   = r_den;
    assign o_side  = r_side;

endmodule

/* rtl/pthm_div.sv */
// ----------------------------------------------------------------------------
// Homography pipelined divider
// Two restoring divider lanes sharing one divisor, one quotient bit per
// stage, with an overflow check up front and saturation at the end.
// ----------------------------------------------------------------------------
module pthm_div
    import pthm_pkg::*;
#(
    parameter int PIXEL_BITS = 13,
    localparam int MAG_W = COEF_W + PIXEL_BITS + 3,
    localparam int REM_W = MAG_W + 1,
    localparam int QW    = OUT_W
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  logic [MAG_W-1:0] i_num_u,
    input  logic [MAG_W-1:0] i_num_v,
    input  logic [MAG_W-1:0] i_den,
    input  t_side            i_side,
    output logic             o_valid,
    output logic [OUT_W-1:0] o_scene_x,
    output logic [OUT_W-1:0] o_scene_y,
    output t_side            o_side
);

    logic [REM_W-1:0] r_rem [2][QW+1];
    logic [MAG_W-1:0] r_num [2][QW+1];
    logic [QW-1:0]    r_q   [2][QW+1];
    logic             r_ovf [2][QW+1];
    logic [MAG_W-1:0] r_den [QW+1];
    t_side            r_side [QW+1];
    logic             r_vld [QW+1];
    logic [OUT_W-1:0] r_res [2];
    t_side            r_side_out;
    logic             r_vld_out;

    logic [MAG_W+OUT_INT_BITS-1:0] den_sh;

    assign den_sh = {i_den, {OUT_INT_BITS{1'b0}}};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0]  <= 1'b0;
            r_vld_out <= 1'b0;
        end else if (i_en) begin
            r_vld[0]  <= i_valid;
            r_vld_out <= r_vld[QW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_den[0]   <= i_den;
            r_side[0]  <= i_side;
            r_side_out <= r_side[QW];
        end
    end

    for (genvar l = 0; l < 2; l++) begin : g_lane
        logic [MAG_W-1:0] lane_num;
        logic             lane_neg;
        logic [OUT_W-1:0] lane_lim;
        logic [OUT_W-1:0] lane_mag;
        logic [OUT_W-1:0] n_res;

        assign lane_num = (l == 0) ? i_num_u : i_num_v;
        assign lane_neg = (l == 0) ? r_side[QW].neg_u : r_side[QW].neg_v;

        always_comb begin
            lane_lim = lane_neg ? OUT_NEG_MAX : OUT_POS_MAX;
            lane_mag = (r_ovf[l][QW] || (r_q[l][QW] > lane_lim)) ? lane_lim : r_q[l][QW];
            if (r_side[QW].zero) begin
                n_res = '0;
            end else if (lane_neg) begin
                n_res = '0 - lane_mag;
            end else begin
                n_res = lane_mag;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_ovf[l][0] <= ({{OUT_INT_BITS{1'b0}}, lane_num} >= den_sh);
                r_rem[l][0] <= REM_W'(lane_num >> OUT_INT_BITS);
                r_num[l][0] <= lane_num;
                r_q[l][0]   <= '0;
                r_res[l]    <= n_res;
            end
        end
    end

    for (genvar j = 0; j < QW; j++) begin : g_stage
        localparam int BIT = QW - 1 - j;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[j+1] <= 1'b0;
            end else if (i_en) begin
                r_vld[j+1] <= r_vld[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_den[j+1]  <= r_den[j];
                r_side[j+1] <= r_side[j];
            end
        end

        for (genvar l = 0; l < 2; l++) begin : g_bit
            logic             nbit;
            logic [REM_W-1:0] shifted;
            logic [REM_W:0]   diff;

            if (BIT >= OUT_FRAC_BITS) begin : g_num_bit
                assign nbit = r_num[l][j][BIT-OUT_FRAC_BITS];
            end else begin : g_frac_bit
                assign nbit = 1'b0;
            end

            assign shifted = {r_rem[l][j][REM_W-2:0], nbit};
            assign diff    = {1'b0, shifted} - {2'b00, r_den[j]};

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[l][j+1] <= diff[REM_W] ? shifted : diff[REM_W-1:0];
                    r_q[l][j+1]   <= {r_q[l][j][QW-2:0], ~diff[REM_W]};
                    r_num[l][j+1] <= r_num[l][j];
                    r_ovf[l][j+1] <= r_ovf[l][j];
                end
            end
        end
    end

    assign o_valid   = r_vld_out;
    assign o_scene_x = r_res[0];
    assign o_scene_y = r_res[1];
    assign o_side    = r_side_out;

endmodule

/* rtl/pixel_to_plane_homography_map_core.sv */
// ----------------------------------------------------------------------------
// Pixel to ground plane homography map
// Maps pixel (x, y, 1) through a 3x3 matrix and returns u/w and v/w in Q31.16.
// ----------------------------------------------------------------------------
// The block takes one word per clock and returns one word per clock while
// o_in_ready and i_out_ready are high. A word is registered in the product
// stage at the edge that accepts it, then passes through the row sums and the
// magnitudes, the overflow check, the restoring division at one quotient bit
// per stage, the saturation and the output register. Results pass through a
// two-entry output buffer; o_in_ready is low only while both of its entries
// hold words, and the whole pipeline then holds. Coefficients are written
// through the plain write port, and the user must write them only while no
// word is in flight; the block has no check for this.
module pixel_to_plane_homography_map_core
    import pthm_pkg::*;
#(
    parameter int PIXEL_BITS     = 13,
    parameter int COEF_FRAC_BITS = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [PIXEL_BITS-1:0]      i_pixel_x,
    input  logic [PIXEL_BITS-1:0]      i_pixel_y,
    input  logic signed [HEIGHT_W-1:0] i_height_in,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic signed [OUT_W-1:0]    o_scene_x,
    output logic signed [OUT_W-1:0]    o_scene_y,
    output logic signed [HEIGHT_W-1:0] o_height_out,
    output logic                       o_zero_divisor,
    input  logic                       i_cfg_we,
    input  logic [CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [CFG_W-1:0]           i_cfg_data
);

    localparam int MAG_W = COEF_W + PIXEL_BITS + 3;

    t_coefs           coefs;
    logic             en;
    logic             dot_valid;
    logic [MAG_W-1:0] dot_num_u;
    logic [MAG_W-1:0] dot_num_v;
    logic [MAG_W-1:0] dot_den;
    t_side            dot_side;
    logic             div_valid;
    logic [OUT_W-1:0] div_x;
    logic [OUT_W-1:0] div_y;
    t_side            div_side;
    t_result          div_res;
    logic             push;
    logic             pop;

    logic             r_out_valid;
    logic             r_skid_valid;
    t_result          r_out;
    t_result          r_skid;

    assign en = !(r_out_valid && r_skid_valid);

    pthm_cfg_regs #(
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_coefs     (coefs)
    );

    pthm_dot #(
        .PIXEL_BITS (PIXEL_BITS)
    ) u_dot (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (en),
        .i_valid   (i_in_valid),
        .i_pixel_x (i_pixel_x),
        .i_pixel_y (i_pixel_y),
        .i_height  (i_height_in),
        .i_coefs   (coefs),
        .o_valid   (dot_valid),
        .o_num_u   (dot_num_u),
        .o_num_v   (dot_num_v),
        .o_den     (dot_den),
        .o_side    (dot_side)
    );

    pthm_div #(
        .PIXEL_BITS (PIXEL_BITS)
    ) u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (en),
        .i_valid   (dot_valid),
        .i_num_u   (dot_num_u),
        .i_num_v   (dot_num_v),
        .i_den     (dot_den),
        .i_side    (dot_side),
        .o_valid   (div_valid),
        .o_scene_x (div_x),
        .o_scene_y (div_y),
        .o_side    (div_side)
    );

    assign div_res.scene_x = div_x;
    assign div_res.scene_y = div_y;
    assign div_res.height  = div_side.height;
    assign div_res.zero    = div_side.zero;

    assign push = div_valid && en;
    assign pop  = r_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (pop) begin
                r_out        <= r_skid;
                r_skid_valid <= 1'b0;
            end
        end else if (!r_out_valid || pop) begin
            r_out_valid <= push;
            if (push) begin
                r_out <= div_res;
            end
        end else if (push) begin
            r_skid       <= div_res;
            r_skid_valid <= 1'b1;
        end
    end

    assign o_in_ready     = en;
    assign o_out_valid    = r_out_valid;
    assign o_scene_x      = r_out.scene_x;
    assign o_scene_y      = r_out.scene_y;
    assign o_height_out   = r_out.height;
    assign o_zero_divisor = r_out.zero;

`ifndef SYNTHESIS
    a_skid_needs_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("output buffer holds a word behind an empty head");

    a_zero_divisor_coords: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_zero_divisor) |-> (o_scene_x == '0 && o_scene_y == '0))
        else $error("zero divisor word carries nonzero coordinates");

    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && !r_skid_valid))
        else $error("output buffer not empty after reset");

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_skid_valid && !i_out_ready) |=> (r_out_valid && r_skid_valid))
        else $error("full output buffer changed without a pop");
`endif

endmodule

/* test/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Homography map core testbench
// Drives pixel words through the pixel to plane homography map, checks every
// result word field by field against fixed expected values or a local predictor
// of u/w and v/w, and steps through identity, extreme, saturating, horizon and
// random matrices.
module tb;
    import pthm_pkg::*;

    localparam int PIX_W = 13;
    localparam logic [PIX_W-1:0] PIX_MAX = {PIX_W{1'b1}};
    localparam int LIMIT_CYCLES = 200000;
    localparam int PHASES = 8;
    localparam int WORDS_PER_PHASE = 240;
    localparam int DRAIN_CYCLES = 60;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;

    typedef enum logic {ROW_REG, ROW_PIX} t_row_kind;
    typedef enum int {MAT_PERSPECTIVE, MAT_RANDOM, MAT_HORIZON, MAT_NEAR_AFFINE} t_matrix_kind;

    typedef struct packed {
        t_row_kind            kind;
        logic [CFG_IDX_W-1:0] idx;
        logic [CFG_W-1:0]     data;
        logic [PIX_W-1:0]     px;
        logic [PIX_W-1:0]     py;
        logic [HEIGHT_W-1:0]  h;
        logic                 typed;
        t_result              want;
    } t_row;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       i_in_valid;
    logic                       o_in_ready;
    logic [PIX_W-1:0]           i_pixel_x;
    logic [PIX_W-1:0]           i_pixel_y;
    logic signed [HEIGHT_W-1:0] i_height_in;
    logic                       o_out_valid;
    logic                       i_out_ready;
    logic signed [OUT_W-1:0]    o_scene_x;
    logic signed [OUT_W-1:0]    o_scene_y;
    logic signed [HEIGHT_W-1:0] o_height_out;
    logic                       o_zero_divisor;
    logic                       i_cfg_we;
    logic [CFG_IDX_W-1:0]       i_cfg_index;
    logic [CFG_W-1:0]           i_cfg_data;

    t_coefs  coef_mirror;
    t_result pending_points[$];
    t_result want;
    t_row    dir_rows[$];

    int errors = 0;
    int cycles = 0;
    int words_in = 0;
    int words_out = 0;
    int zero_seen = 0;
    int sat_seen = 0;
    int settings_used = 1;
    int rx_hold = 0;
    bit rx_calm = 0;
    bit tx_calm = 0;

    pixel_to_plane_homography_map_core DUT (.*);

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT_CYCLES) begin
            $display("%0t: timeout with %0d words outstanding", $time, pending_points.size());
            $display("tb: failure");
            $finish;
        end
    end

    // u/w scaled by 2^16, truncated toward zero and clamped to the 48-bit range.
    function automatic logic [OUT_W-1:0] scaled_quotient(input longint num, input longint den);
        logic [127:0] n;
        logic [127:0] d;
        logic [127:0] q;
        logic [127:0] lim;
        logic         neg;
        neg = (num < 0) != (den < 0);
        n = (num < 0) ? 128'(-num) : 128'(num);
        d = (den < 0) ? 128'(-den) : 128'(den);
        q = (n << OUT_FRAC_BITS) / d;
        lim = neg ? 128'(OUT_NEG_MAX) : 128'(OUT_POS_MAX);
        if (q > lim) begin
            q = lim;
        end
        if (neg) begin
            q = -q;
        end
        return q[OUT_W-1:0];
    endfunction

    function automatic t_result predict_point(input logic [PIX_W-1:0] px,
                                              input logic [PIX_W-1:0] py,
                                              input logic [HEIGHT_W-1:0] h);
        longint  x;
        longint  y;
        longint  u;
        longint  v;
        longint  w;
        t_result r;
        x = px;
        y = py;
        u = longint'(coef_mirror.h00) * x + longint'(coef_mirror.h01) * y
            + longint'(coef_mirror.h02);
        v = longint'(coef_mirror.h10) * x + longint'(coef_mirror.h11) * y
            + longint'(coef_mirror.h12);
        w = longint'(coef_mirror.h20) * x + longint'(coef_mirror.h21) * y
            + longint'(coef_mirror.h22);
        r.height = h;
        r.zero = (w == 0);
        if (w == 0) begin
            r.scene_x = '0;
            r.scene_y = '0;
        end else begin
            r.scene_x = scaled_quotient(u, w);
            r.scene_y = scaled_quotient(v, w);
        end
        return r;
    endfunction

    function automatic void mirror_reg(input logic [CFG_IDX_W-1:0] idx,
                                       input logic [CFG_W-1:0] data);
        case (idx)
            CFG_ROW0_A: begin
                {coef_mirror.h01, coef_mirror.h00} = data;
            end
            CFG_ROW0_B_ROW1_A: begin
                {coef_mirror.h10, coef_mirror.h02} = data;
            end
            CFG_ROW1_B: begin
                {coef_mirror.h12, coef_mirror.h11} = data;
            end
            CFG_ROW2_A: begin
                {coef_mirror.h21, coef_mirror.h20} = data;
            end
            CFG_ROW2_C: begin
                coef_mirror.h22 = data[COEF_W-1:0];
            end
            default: begin
            end
        endcase
    endfunction

    function automatic int spread(input int r);
        return int'($urandom_range(0, 2 * r)) - r;
    endfunction

    function automatic t_row reg_row(input logic [CFG_IDX_W-1:0] idx,
                                     input logic [CFG_W-1:0] data);
        t_row r;
        r = '0;
        r.kind = ROW_REG;
        r.idx = idx;
        r.data = data;
        return r;
    endfunction

    function automatic t_row pix_row(input logic [PIX_W-1:0] px, input logic [PIX_W-1:0] py,
                                     input logic [HEIGHT_W-1:0] h);
        t_row r;
        r = '0;
        r.kind = ROW_PIX;
        r.px = px;
        r.py = py;
        r.h = h;
        return r;
    endfunction

    function automatic t_row chk_row(input logic [PIX_W-1:0] px, input logic [PIX_W-1:0] py,
                                     input logic [HEIGHT_W-1:0] h, input logic [OUT_W-1:0] ex,
                                     input logic [OUT_W-1:0] ey, input logic z);
        t_row r;
        r = pix_row(px, py, h);
        r.typed = 1'b1;
        r.want.scene_x = ex;
        r.want.scene_y = ey;
        r.want.height = h;
        r.want.zero = z;
        return r;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        mirror_reg(idx, data);
    endtask

    task automatic send_word(input logic [PIX_W-1:0] px, input logic [PIX_W-1:0] py,
                             input logic [HEIGHT_W-1:0] h, input logic typed,
                             input t_result fixed);
        t_result exp_word;
        int      gap;
        gap = tx_calm ? 0 : $urandom_range(0, 3);
        if ($urandom_range(0, 39) == 0) begin
            tx_calm = !tx_calm;
        end
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_pixel_x <= px;
        i_pixel_y <= py;
        i_height_in <= h;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        exp_word = typed ? fixed : predict_point(px, py, h);
        pending_points = {pending_points, exp_word};
        words_in++;
    endtask

    task automatic drain_points;
        i_in_valid <= 1'b0;
        while (pending_points.size() != 0) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            rx_hold = 0;
        end else if (i_out_ready && o_out_valid) begin
            if (pending_points.size() == 0) begin
                $display("%0t: word with nothing expected: x=%h y=%h", $time,
                         o_scene_x, o_scene_y);
                errors++;
            end else begin
                want = pending_points.pop_front();
                if (o_scene_x !== want.scene_x) begin
                    $display("%0t: scene_x expected %h actual %h", $time,
                             want.scene_x, o_scene_x);
                    errors++;
                end
                if (o_scene_y !== want.scene_y) begin
                    $display("%0t: scene_y expected %h actual %h", $time,
                             want.scene_y, o_scene_y);
                    errors++;
                end
                if (o_height_out !== want.height) begin
                    $display("%0t: height_out expected %h actual %h", $time,
                             want.height, o_height_out);
                    errors++;
                end
                if (o_zero_divisor !== want.zero) begin
                    $display("%0t: zero_divisor expected %b actual %b", $time,
                             want.zero, o_zero_divisor);
                    errors++;
                end
                words_out++;
                if (want.zero) begin
                    zero_seen++;
                end
                if (want.scene_x == OUT_POS_MAX || want.scene_x == OUT_NEG_MAX
                        || want.scene_y == OUT_POS_MAX || want.scene_y == OUT_NEG_MAX) begin
                    sat_seen++;
                end
            end
            if ($urandom_range(0, 39) == 0) begin
                rx_calm = !rx_calm;
            end
            rx_hold = rx_calm ? 0 : $urandom_range(0, 3);
            i_out_ready <= (rx_hold == 0);
        end else if (!i_out_ready) begin
            if (rx_hold <= 1) begin
                i_out_ready <= 1'b1;
            end
            rx_hold = rx_hold - 1;
        end
    end

    initial begin
        t_row             row;
        t_coefs           hm;
        t_matrix_kind     mat;
        logic [PIX_W-1:0] px;
        logic [PIX_W-1:0] py;

        i_rst_n <= 1'b0;
        i_in_valid <= 1'b0;
        i_pixel_x <= '0;
        i_pixel_y <= '0;
        i_height_in <= '0;
        i_cfg_we <= 1'b0;
        i_cfg_index <= CFG_ROW0_A;
        i_cfg_data <= '0;

        coef_mirror = '0;
        coef_mirror.h00 = 32'sh0001_0000;
        coef_mirror.h11 = 32'sh0001_0000;
        coef_mirror.h22 = 32'sh0001_0000;

        dir_rows = '{
            chk_row(0, 0, 32'h0000_0000, 48'h0, 48'h0, 1'b0),
            chk_row(PIX_MAX, PIX_MAX, 32'h7FFF_FFFF, 48'h1FFF_0000, 48'h1FFF_0000, 1'b0),
            chk_row(1, PIX_MAX, 32'h8000_0000, 48'h1_0000, 48'h1FFF_0000, 1'b0),
            pix_row(13'h1555, 13'h0AAA, 32'hAAAA_5555),
            reg_row(CFG_ROW2_C, 64'hFFFF_FFFF_0000_0000),
            chk_row(0, 0, 32'h1234_5678, 48'h0, 48'h0, 1'b1),
            chk_row(PIX_MAX, 0, 32'h8000_0000, 48'h0, 48'h0, 1'b1),
            reg_row(CFG_ROW0_A, {32'h8000_0000, 32'h7FFF_FFFF}),
            reg_row(CFG_ROW2_C, 64'h0000_0000_0000_0001),
            reg_row(CFG_SPARE_A, 64'hFFFF_FFFF_FFFF_FFFF),
            chk_row(PIX_MAX, 0, 32'h0000_0001, OUT_POS_MAX, 48'h0, 1'b0),
            chk_row(0, PIX_MAX, 32'hFFFF_FFFF, OUT_NEG_MAX, 48'h1FFF_0000_0000, 1'b0),
            chk_row(0, 0, 32'h0000_0000, 48'h0, 48'h0, 1'b0),
            reg_row(CFG_ROW2_C, 64'h0000_0000_FFFF_FFFF),
            chk_row(PIX_MAX, 0, 32'h5555_AAAA, OUT_NEG_MAX, 48'h0, 1'b0),
            chk_row(0, PIX_MAX, 32'h0F0F_0F0F, OUT_POS_MAX, 48'hE001_0000_0000, 1'b0),
            reg_row(CFG_ROW0_B_ROW1_A, {32'h8000_0000, 32'h7FFF_FFFF}),
            reg_row(CFG_ROW1_B, {32'h8000_0000, 32'h7FFF_FFFF}),
            reg_row(CFG_ROW2_A, {32'h7FFF_FFFF, 32'h8000_0000}),
            reg_row(CFG_ROW2_C, 64'h0000_0000_7FFF_FFFF),
            reg_row(CFG_SPARE_B, 64'h0123_4567_89AB_CDEF),
            pix_row(0, 0, 32'h0000_0000),
            pix_row(PIX_MAX, PIX_MAX, 32'hFFFF_FFFF),
            pix_row(1, 0, 32'h8000_0001),
            pix_row(PIX_MAX, 0, 32'h7FFF_FFFE),
            pix_row(0, PIX_MAX, 32'h0000_0001),
            reg_row(CFG_ROW2_A, {32'hFFFF_0000, 32'h0001_0000}),
            reg_row(CFG_ROW2_C, 64'h0000_0000_0000_0000),
            chk_row(100, 100, 32'h0000_FFFF, 48'h0, 48'h0, 1'b1),
            pix_row(101, 100, 32'hC000_0000),
            pix_row(100, 101, 32'h3FFF_FFFF)
        };

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[k]) begin
            row = dir_rows[k];
            if (row.kind == ROW_REG) begin
                drain_points();
                write_reg(row.idx, row.data);
            end else begin
                i_cfg_we <= 1'b0;
                send_word(row.px, row.py, row.h, row.typed, row.want);
            end
        end

        for (int p = 0; p < PHASES; p++) begin
            drain_points();
            mat = t_matrix_kind'(p % 4);
            hm.h00 = spread(1 << 18);
            hm.h01 = spread(1 << 18);
            hm.h02 = spread(1 << 28);
            hm.h10 = spread(1 << 18);
            hm.h11 = spread(1 << 18);
            hm.h12 = spread(1 << 28);
            hm.h20 = spread(1 << 6);
            hm.h21 = spread(1 << 6);
            hm.h22 = 65536 + spread(1 << 15);
            case (mat)
                MAT_RANDOM: begin
                    hm = {$urandom, $urandom, $urandom, $urandom, $urandom,
                          $urandom, $urandom, $urandom, $urandom};
                end
                MAT_HORIZON: begin
                    hm.h20 = spread(1 << 16);
                    hm.h21 = -hm.h20;
                    hm.h22 = '0;
                end
                MAT_NEAR_AFFINE: begin
                    hm.h20 = '0;
                    hm.h21 = '0;
                    hm.h22 = spread(8);
                end
                default: begin
                end
            endcase
            write_reg(CFG_ROW0_A, {hm.h01, hm.h00});
            write_reg(CFG_ROW0_B_ROW1_A, {hm.h10, hm.h02});
            write_reg(CFG_ROW1_B, {hm.h12, hm.h11});
            write_reg(CFG_ROW2_A, {hm.h21, hm.h20});
            write_reg(CFG_ROW2_C, {32'($urandom), hm.h22});
            write_reg($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B,
                      {32'($urandom), 32'($urandom)});
            i_cfg_we <= 1'b0;
            settings_used++;

            for (int n = 0; n < WORDS_PER_PHASE; n++) begin
                case ($urandom_range(0, 7))
                    0: begin
                        px = $urandom_range(0, 1) ? PIX_MAX : '0;
                        py = $urandom_range(0, 1) ? PIX_MAX : '0;
                    end
                    1: begin
                        px = PIX_W'($urandom);
                        py = px;
                    end
                    2: begin
                        px = PIX_W'($urandom_range(0, 15));
                        py = PIX_W'($urandom_range(0, 15));
                    end
                    default: begin
                        px = PIX_W'($urandom);
                        py = PIX_W'($urandom);
                    end
                endcase
                if (mat == MAT_HORIZON && $urandom_range(0, 1) == 1) begin
                    py = px;
                end
                send_word(px, py, $urandom, 1'b0, '0);
                // Hold the source until the pipeline has emptied once mid-stream.
                if (p == 0 && n == WORDS_PER_PHASE / 2) begin
                    drain_points();
                end
            end
        end

        drain_points();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("summary: %0d pixel words under %0d coefficient settings, %0d results checked",
                 words_in, settings_used, words_out);
        $display("summary: %0d results with w zero, %0d with a saturated coordinate",
                 zero_seen, sat_seen);
        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
